// File: sv/playfair_digraph_encryptor_top_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFE_ASSERT_NOW(lbl, ante, cons, msg)
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/pfe_pkg.sv
package pfe_pkg;

  localparam int unsigned SIDE  = 5;
  localparam int unsigned CELLS = 25;
  localparam int unsigned ALPHA = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_PLAIN  = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FILLER = 1'b0,
    REG_PAD    = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic    we;
    cell_t   wcell;
    letter_t wletter;
    logic    pos_re;
    letter_t pos_a;
    letter_t pos_b;
    logic    sq_re;
    cell_t   sq_a;
    cell_t   sq_b;
  } pfe_sq_req_t;

  function automatic letter_t fold_letter(letter_t v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  function automatic coord_t row_of(cell_t p);
    if (p >= 5'd20) return 3'd4;
    else if (p >= 5'd15) return 3'd3;
    else if (p >= 5'd10) return 3'd2;
    else if (p >= 5'd5) return 3'd1;
    else return 3'd0;
  endfunction

  function automatic cell_t cell_at(coord_t r, coord_t c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

  function automatic coord_t col_of(cell_t p);
    cell_t d;
    d = p - cell_at(row_of(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic coord_t wrap_inc(coord_t v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

// File: sv/playfair_digraph_encryptor_top.sv
// Playfair encryptor over letter indices a=0 to z=25.
// Input beats carry a command and a letter: key letter, finish key, plaintext
// letter or end of message. Output beats carry one cipher letter each, and
// tlast marks the second letter of a digraph.
// The key square and the letter position table sit in two small synchronous
// memories. Plaintext and end-of-message beats are ignored until the key is
// finished; key beats are ignored after it.
// Finish key walks the whole alphabet to fill the rest of the square.
// A beat that closes a digraph goes through a position read and a square
// read, then the two cipher letters are loaded into the output buffer. A
// beat that only holds a letter is stored without a memory read.
// If the receiver stalls, a finished digraph waits in the square read stage
// until the two-beat output buffer has drained, and no input is taken.
// Reset (rst, synchronous) empties the key, the held letter and the output
// buffer and restores filler x and pad z; the configuration port writes
// filler (index 0) and pad (index 1). The block does not check its state
// there: the user must write the configuration only while the block is
// idle.
`include "playfair_digraph_encryptor_top_defines.svh"

module playfair_digraph_encryptor_top
  import pfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] command, [6:2] letter, [7] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
  output logic       m_axis_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POS,
    S_SQ
  } state_t;

  state_t      state;
  logic        key_ready;
  cell_t       fill_count;
  logic [25:0] letter_used;
  letter_t     walk;
  logic        held_valid;
  letter_t     held_letter;
  letter_t     filler_letter;
  letter_t     pad_letter;
  logic        out_valid;
  letter_t     out_letter;
  logic        out_last;
  logic        pend_valid;
  letter_t     pend_letter;

  pfe_sq_req_t req;
  cell_t       pos_a_q;
  cell_t       pos_b_q;
  letter_t     sq_a_q;
  letter_t     sq_b_q;

  logic    accept;
  cmd_t    cmd;
  letter_t raw;
  letter_t plain;
  logic    raw_ok;
  logic    key_place;
  logic    fill_place;
  logic    start_pair;
  logic    pair_doubled;
  letter_t second;
  coord_t  ra;
  coord_t  ca;
  coord_t  rb;
  coord_t  cb;
  logic    load_out;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_t'(s_axis_tdata[1:0]);
  assign raw           = s_axis_tdata[6:2];
  assign raw_ok        = (raw < 5'(ALPHA));
  assign plain         = fold_letter(raw);
  assign pair_doubled  = (plain == held_letter);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_letter};
  assign m_axis_tlast  = out_last;

  always_comb begin
    key_place  = accept && (cmd == CMD_KEY) && !key_ready && raw_ok &&
                 (raw != LETTER_J) && !letter_used[raw] && (fill_count < 5'(CELLS));
    fill_place = (state == S_FILL) && (walk != LETTER_J) && !letter_used[walk] &&
                 (fill_count < 5'(CELLS));
    start_pair = accept && key_ready && held_valid &&
                 (((cmd == CMD_PLAIN) && raw_ok) || (cmd == CMD_END));
    if (cmd == CMD_END) begin
      second = fold_letter(pad_letter);
    end else if (pair_doubled) begin
      second = fold_letter(filler_letter);
    end else begin
      second = plain;
    end

    ra = row_of(pos_a_q);
    ca = col_of(pos_a_q);
    rb = row_of(pos_b_q);
    cb = col_of(pos_b_q);

    req.we      = key_place || fill_place;
    req.wcell   = fill_count;
    req.wletter = key_place ? raw : walk;
    req.pos_re  = start_pair;
    req.pos_a   = held_letter;
    req.pos_b   = second;
    req.sq_re   = (state == S_POS);
    if (ra == rb) begin
      req.sq_a = cell_at(ra, wrap_inc(ca));
      req.sq_b = cell_at(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      req.sq_a = cell_at(wrap_inc(ra), ca);
      req.sq_b = cell_at(wrap_inc(rb), cb);
    end else begin
      req.sq_a = cell_at(ra, cb);
      req.sq_b = cell_at(rb, ca);
    end

    load_out = (state == S_SQ) && !out_valid;
  end

  pfe_sq u_sq (
    .clk     (clk),
    .req     (req),
    .pos_a_q (pos_a_q),
    .pos_b_q (pos_b_q),
    .sq_a_q  (sq_a_q),
    .sq_b_q  (sq_b_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      key_ready     <= 1'b0;
      fill_count    <= '0;
      letter_used   <= '0;
      walk          <= '0;
      held_valid    <= 1'b0;
      held_letter   <= '0;
      filler_letter <= 5'd23;
      pad_letter    <= LETTER_Z;
      out_valid     <= 1'b0;
      out_last      <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_FILLER: filler_letter <= cfg_data;
          REG_PAD:    pad_letter    <= cfg_data;
          default:    filler_letter <= filler_letter;
        endcase
      end

      if (req.we) begin
        fill_count              <= fill_count + 5'd1;
        letter_used[req.wletter] <= 1'b1;
      end

      if (out_valid && m_axis_tready) begin
        if (pend_valid) begin
          out_letter <= pend_letter;
          out_last   <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_FINISH: begin
                if (!key_ready) begin
                  walk  <= '0;
                  state <= S_FILL;
                end
              end
              CMD_PLAIN: begin
                if (key_ready && raw_ok) begin
                  held_letter <= plain;
                  held_valid  <= !held_valid || pair_doubled;
                end
              end
              CMD_END: begin
                if (key_ready) begin
                  held_valid <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            if (start_pair) begin
              state <= S_POS;
            end
          end
        end
        S_FILL: begin
          walk <= walk + 5'd1;
          if (walk == 5'(ALPHA - 1)) begin
            key_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_POS: begin
          state <= S_SQ;
        end
        S_SQ: begin
          if (load_out) begin
            out_valid   <= 1'b1;
            out_letter  <= sq_a_q;
            out_last    <= 1'b0;
            pend_valid  <= 1'b1;
            pend_letter <= sq_b_q;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PFE_ASSERT_NOW(a_pend_has_head, pend_valid, out_valid, "second cipher letter without first")
  `PFE_ASSERT_NOW(a_no_write_after_key, req.we, !key_ready, "square written after key finished")
  `PFE_ASSERT_NOW(a_key_full, key_ready, fill_count == 5'(CELLS), "finished key square not full")
  `PFE_ASSERT_NEXT(a_pair_to_sq, state == S_POS, state == S_SQ, "position read not followed")
  `PFE_ASSERT_NOW(a_no_read_before_key, req.pos_re, key_ready, "lookup before key finished")

endmodule

// File: sv/pfe_sq.sv
module pfe_sq
  import pfe_pkg::*;
(
  input  logic        clk,
  input  pfe_sq_req_t req,
  output cell_t       pos_a_q,
  output cell_t       pos_b_q,
  output letter_t     sq_a_q,
  output letter_t     sq_b_q
);

  letter_t square_mem [CELLS];
  cell_t   pos_mem [ALPHA];

  always_ff @(posedge clk) begin
    if (req.we) begin
      square_mem[req.wcell]  <= req.wletter;
      pos_mem[req.wletter]   <= req.wcell;
    end
    if (req.pos_re) begin
      pos_a_q <= pos_mem[req.pos_a];
      pos_b_q <= pos_mem[req.pos_b];
    end
    if (req.sq_re) begin
      sq_a_q <= square_mem[req.sq_a];
      sq_b_q <= square_mem[req.sq_b];
    end
  end

endmodule
